// ===== design/header_length_trailer_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the header/length/trailer deframer
// Clocked property wrappers with an optional reset qualifier.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_ASSERT_SVH

// checked only while out of reset
`define HLTD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HLTD_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hltd_pkg.sv =====
// ----------------------------------------------------------------------------
// hltd_pkg
// Types and constants shared by the header/length/trailer deframer.
// ----------------------------------------------------------------------------
package hltd_pkg;

	localparam logic [31:0] TRAILER_WORD       = 32'h9999_9999;
	localparam logic [31:0] HEADER_WORD_RST    = 32'h01CC_CCCC;
	localparam logic [30:0] PACKET_LIMIT_RST   = 31'h7FFF_FFFF;
	localparam logic [32:0] MAX_PAYLOAD_RST    = 33'd19980;
	localparam logic [30:0] GOOD_COUNT_MAX     = 31'h7FFF_FFFF;
	localparam int          CFG_INDEX_W        = 2;
	localparam int          CFG_DATA_W         = 33;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HEADER_WORD  = 2'd0,
		CFG_PACKET_LIMIT = 2'd1,
		CFG_MAX_PAYLOAD  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_PRE  = 2'd1,
		PH_PAY  = 2'd2,
		PH_TRL  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_HUNT     = 3'd0,
		ROLE_HEADER   = 3'd1,
		ROLE_PREAMBLE = 3'd2,
		ROLE_PAYLOAD  = 3'd3,
		ROLE_TRAILER  = 3'd4,
		ROLE_IGNORED  = 3'd5
	} role_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic [30:0] packet_limit;
		logic [32:0] max_payload_bytes;
	} hltd_cfg_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		role_t       byte_role;
		logic        frame_end;
		logic        frame_good;
		logic        frame_too_long;
		logic [31:0] trigger_number;
		logic [31:0] frame_counter;
		logic [32:0] payload_bytes;
		logic [30:0] good_frames;
		logic        limit_reached;
	} hltd_result_t;

endpackage

// ===== design/hltd_cfg.sv =====
// ----------------------------------------------------------------------------
// hltd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hltd_cfg
	import hltd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	output hltd_cfg_t              cfg
);

	hltd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word       <= HEADER_WORD_RST;
			cfg_q.packet_limit      <= PACKET_LIMIT_RST;
			cfg_q.max_payload_bytes <= MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HEADER_WORD:  cfg_q.header_word       <= cfg_wr_data[31:0];
				CFG_PACKET_LIMIT: cfg_q.packet_limit      <= cfg_wr_data[30:0];
				CFG_MAX_PAYLOAD:  cfg_q.max_payload_bytes <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/hltd_core.sv =====
// ----------------------------------------------------------------------------
// hltd_core
// Frame state machine: header hunt, preamble capture, payload count,
// trailer check. One byte per accepted request.
// ----------------------------------------------------------------------------
module hltd_core
	import hltd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   rx_byte,
	input  hltd_cfg_t    cfg,
	output hltd_result_t res
);

	phase_t      phase_q, phase_d;
	logic [31:0] window_q, window_d;
	logic [2:0]  fill_q, fill_d;
	logic [3:0]  pidx_q, pidx_d;
	logic [31:0] trig_q, trig_d;
	logic [31:0] cnt_q, cnt_d;
	logic [32:0] len_q, len_d;
	logic [32:0] left_q, left_d;
	logic [31:0] tsh_q, tsh_d;
	logic [30:0] good_q, good_d;
	logic [32:0] dbl_len;
	logic [32:0] left_dec;
	logic        fend, fgood, flong;
	role_t       role;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			fill_q   <= '0;
			pidx_q   <= '0;
			trig_q   <= '0;
			cnt_q    <= '0;
			len_q    <= '0;
			left_q   <= '0;
			tsh_q    <= '0;
			good_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			pidx_q   <= pidx_d;
			trig_q   <= trig_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			left_q   <= left_d;
			tsh_q    <= tsh_d;
			good_q   <= good_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		fill_d   = fill_q;
		pidx_d   = pidx_q;
		trig_d   = trig_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		left_d   = left_q;
		tsh_d    = tsh_q;
		good_d   = good_q;
		role     = ROLE_HUNT;
		fend     = 1'b0;
		fgood    = 1'b0;
		flong    = 1'b0;
		dbl_len  = '0;
		left_dec = (left_q != '0) ? left_q - 33'd1 : left_q;

		unique case (phase_q)
			PH_HUNT: begin
				if (good_q >= cfg.packet_limit) begin
					role = ROLE_IGNORED;
				end else begin
					window_d = {window_q[23:0], rx_byte};
					if (fill_q < 3'd4)
						fill_d = fill_q + 3'd1;
					if (fill_d >= 3'd4 && window_d == cfg.header_word) begin
						role    = ROLE_HEADER;
						phase_d = PH_PRE;
						pidx_d  = '0;
					end
				end
			end
			PH_PRE: begin
				role = ROLE_PREAMBLE;
				if (pidx_q < 4'd4)
					trig_d = {rx_byte, trig_q[31:8]};
				else if (pidx_q < 4'd8)
					cnt_d = {rx_byte, cnt_q[31:8]};
				else
					len_d = {1'b0, rx_byte, len_q[31:8]};
				if (pidx_q >= 4'd11) begin
					dbl_len = {len_d[31:0], 1'b0};
					len_d   = dbl_len;
					if (dbl_len > cfg.max_payload_bytes) begin
						fend     = 1'b1;
						flong    = 1'b1;
						phase_d  = PH_HUNT;
						window_d = '0;
						fill_d   = '0;
					end else if (dbl_len == '0) begin
						phase_d = PH_TRL;
						pidx_d  = '0;
						tsh_d   = '0;
					end else begin
						phase_d = PH_PAY;
						left_d  = dbl_len;
					end
				end else begin
					pidx_d = pidx_q + 4'd1;
				end
			end
			PH_PAY: begin
				role   = ROLE_PAYLOAD;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_TRL;
					pidx_d  = '0;
					tsh_d   = '0;
				end
			end
			PH_TRL: begin
				role  = ROLE_TRAILER;
				tsh_d = {tsh_q[23:0], rx_byte};
				if (pidx_q >= 4'd3) begin
					fend = 1'b1;
					if (tsh_d == TRAILER_WORD) begin
						fgood = 1'b1;
						if (good_q != GOOD_COUNT_MAX)
							good_d = good_q + 31'd1;
					end
					phase_d  = PH_HUNT;
					window_d = '0;
					fill_d   = '0;
				end else begin
					pidx_d = pidx_q + 4'd1;
				end
			end
			default: ;
		endcase

		res.byte_out       = rx_byte;
		res.byte_role      = role;
		res.frame_end      = fend;
		res.frame_good     = fgood;
		res.frame_too_long = flong;
		res.trigger_number = trig_d;
		res.frame_counter  = cnt_d;
		res.payload_bytes  = len_d;
		res.good_frames    = good_d;
		res.limit_reached  = (good_d >= cfg.packet_limit);
	end

endmodule

// ===== design/hltd_out.sv =====
// ----------------------------------------------------------------------------
// hltd_out
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module hltd_out
	import hltd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         take,
	input  hltd_result_t res,
	output logic         out_valid,
	input  logic         out_stall,
	output hltd_result_t res_out
);

	logic         valid_q;
	hltd_result_t res_q;

	// the register frees up in the same cycle its request is taken
	assign in_stall = valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res;
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

// ===== design/header_length_trailer_deframer.sv =====
// ----------------------------------------------------------------------------
// header_length_trailer_deframer
// Byte-stream deframer: header hunt, preamble capture, payload count and
// trailer check, with each byte echoed along with its role.
// ----------------------------------------------------------------------------
// One request is one byte and yields exactly one result request. A byte is
// taken every cycle the consumer does not stall; its result appears in the
// next cycle in the output register, which is the only stage. The whole
// per-byte decision (window compare, length doubling and limit compare,
// trailer compare) sits between the state registers and that register.
// A new byte is still taken while a result waits, as long as the consumer
// takes it in that same cycle. No start-up pass after reset. Write the
// configuration registers only while no byte is in flight.
module header_length_trailer_deframer
	import hltd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             byte_out,
	output logic [2:0]             byte_role,
	output logic                   frame_end,
	output logic                   frame_good,
	output logic                   frame_too_long,
	output logic [31:0]            trigger_number,
	output logic [31:0]            frame_counter,
	output logic [32:0]            payload_bytes,
	output logic [30:0]            good_frames,
	output logic                   limit_reached
);

	hltd_cfg_t    cfg;
	hltd_result_t res;
	hltd_result_t res_out;
	logic         take;

	hltd_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	hltd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.res     (res)
	);

	hltd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.take      (take),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign byte_out       = res_out.byte_out;
	assign byte_role      = res_out.byte_role;
	assign frame_end      = res_out.frame_end;
	assign frame_good     = res_out.frame_good;
	assign frame_too_long = res_out.frame_too_long;
	assign trigger_number = res_out.trigger_number;
	assign frame_counter  = res_out.frame_counter;
	assign payload_bytes  = res_out.payload_bytes;
	assign good_frames    = res_out.good_frames;
	assign limit_reached  = res_out.limit_reached;

endmodule

// ===== design/hltd_checker.sv =====
// ----------------------------------------------------------------------------
// hltd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "header_length_trailer_deframer_assert.svh"

module hltd_checker
	import hltd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [7:0]             byte_out,
	input logic [2:0]             byte_role,
	input logic                   frame_end,
	input logic                   frame_good,
	input logic                   frame_too_long,
	input logic                   limit_reached
);

	`HLTD_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(byte_out), "stalled result changed")
	`HLTD_ASSERT_ALWAYS(a_stall_needs_result, clk, in_stall |-> out_valid, "input stalled with no result waiting")
	`HLTD_ASSERT(a_good_on_trailer, clk, arst_n, out_valid && frame_good |-> frame_end && byte_role == ROLE_TRAILER && !frame_too_long, "good frame outside trailer end")
	`HLTD_ASSERT(a_long_on_preamble, clk, arst_n, out_valid && frame_too_long |-> frame_end && byte_role == ROLE_PREAMBLE, "oversize abort outside preamble")
	`HLTD_ASSERT(a_ignored_at_limit, clk, arst_n, out_valid && byte_role == ROLE_IGNORED |-> limit_reached && !frame_end, "byte ignored below limit")

endmodule

bind header_length_trailer_deframer hltd_checker u_hltd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.byte_out       (byte_out),
	.byte_role      (byte_role),
	.frame_end      (frame_end),
	.frame_good     (frame_good),
	.frame_too_long (frame_too_long),
	.limit_reached  (limit_reached)
);

// ===== tb/header_length_trailer_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// header_length_trailer_deframer_tb
// Streams bytes into the deframer: directed frames for the header hunt,
// zero and oversize lengths, bad trailers and the good-frame limit, then
// random framed traffic under several register settings. Every echoed byte
// is checked field by field against an in-bench prediction of the deframer.
// ----------------------------------------------------------------------------
module header_length_trailer_deframer_tb;
	import hltd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 1000;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_LONG
	} stall_mode_t;

	class deframer_scoreboard;
		logic [31:0] hdr_word;
		logic [30:0] pkt_limit;
		logic [32:0] max_len;
		phase_t      phase;
		logic [31:0] window;
		int unsigned window_fill;
		logic [3:0]  pre_idx;
		logic [31:0] trig;
		logic [31:0] ctr;
		logic [32:0] len;
		logic [32:0] left;
		logic [31:0] trl;
		logic [30:0] good;
		hltd_result_t expected_echoes[$];
		int unsigned errors;

		function new();
			hdr_word = HEADER_WORD_RST;
			pkt_limit = PACKET_LIMIT_RST;
			max_len = MAX_PAYLOAD_RST;
			phase = PH_HUNT;
			window = '0;
			window_fill = 0;
			pre_idx = '0;
			trig = '0;
			ctr = '0;
			len = '0;
			left = '0;
			trl = '0;
			good = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [32:0] value);
			case (idx)
				CFG_HEADER_WORD:  hdr_word = value[31:0];
				CFG_PACKET_LIMIT: pkt_limit = value[30:0];
				CFG_MAX_PAYLOAD:  max_len = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_echoes.size();
		endfunction

		function bit limit_hit();
			return good >= pkt_limit;
		endfunction

		function void restart_hunt();
			phase = PH_HUNT;
			window = '0;
			window_fill = 0;
		endfunction

		// advance the deframer state by one byte and queue its echo
		function role_t predict_byte(logic [7:0] value);
			hltd_result_t res;
			res = '0;
			res.byte_out = value;
			case (phase)
				PH_HUNT: begin
					if (good >= pkt_limit) begin
						res.byte_role = ROLE_IGNORED;
					end else begin
						window = {window[23:0], value};
						if (window_fill < 4)
							window_fill++;
						if (window_fill >= 4 && window == hdr_word) begin
							res.byte_role = ROLE_HEADER;
							phase = PH_PRE;
							pre_idx = '0;
						end else begin
							res.byte_role = ROLE_HUNT;
						end
					end
				end
				PH_PRE: begin
					res.byte_role = ROLE_PREAMBLE;
					if (pre_idx < 4)
						trig = {value, trig[31:8]};
					else if (pre_idx < 8)
						ctr = {value, ctr[31:8]};
					else
						len = {1'b0, value, len[31:8]};
					if (pre_idx >= 11) begin
						len = {len[31:0], 1'b0};
						if (len > max_len) begin
							res.frame_end = 1'b1;
							res.frame_too_long = 1'b1;
							restart_hunt();
						end else if (len == '0) begin
							phase = PH_TRL;
							pre_idx = '0;
							trl = '0;
						end else begin
							phase = PH_PAY;
							left = len;
						end
					end else begin
						pre_idx = pre_idx + 1'b1;
					end
				end
				PH_PAY: begin
					res.byte_role = ROLE_PAYLOAD;
					if (left != '0)
						left = left - 1'b1;
					if (left == '0) begin
						phase = PH_TRL;
						pre_idx = '0;
						trl = '0;
					end
				end
				default: begin
					res.byte_role = ROLE_TRAILER;
					trl = {trl[23:0], value};
					if (pre_idx >= 3) begin
						res.frame_end = 1'b1;
						if (trl == TRAILER_WORD) begin
							res.frame_good = 1'b1;
							if (good != GOOD_COUNT_MAX)
								good = good + 1'b1;
						end
						restart_hunt();
					end else begin
						pre_idx = pre_idx + 1'b1;
					end
				end
			endcase
			res.trigger_number = trig;
			res.frame_counter = ctr;
			res.payload_bytes = len;
			res.good_frames = good;
			res.limit_reached = (good >= pkt_limit);
			expected_echoes.push_back(res);
			return res.byte_role;
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(hltd_result_t seen);
			hltd_result_t want;
			if (expected_echoes.size() == 0) begin
				$display("%0t: unexpected result, byte_out %0h", $time, seen.byte_out);
				errors++;
				return;
			end
			want = expected_echoes.pop_front();
			compare_field("byte_out", want.byte_out, seen.byte_out);
			compare_field("byte_role", want.byte_role, seen.byte_role);
			compare_field("frame_end", want.frame_end, seen.frame_end);
			compare_field("frame_good", want.frame_good, seen.frame_good);
			compare_field("frame_too_long", want.frame_too_long, seen.frame_too_long);
			compare_field("trigger_number", want.trigger_number, seen.trigger_number);
			compare_field("frame_counter", want.frame_counter, seen.frame_counter);
			compare_field("payload_bytes", want.payload_bytes, seen.payload_bytes);
			compare_field("good_frames", want.good_frames, seen.good_frames);
			compare_field("limit_reached", want.limit_reached, seen.limit_reached);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             rx_byte;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             byte_out;
	logic [2:0]             byte_role;
	logic                   frame_end;
	logic                   frame_good;
	logic                   frame_too_long;
	logic [31:0]            trigger_number;
	logic [31:0]            frame_counter;
	logic [32:0]            payload_bytes;
	logic [30:0]            good_frames;
	logic                   limit_reached;

	deframer_scoreboard sb;
	int unsigned burst_left = 0;
	int unsigned fed_bytes = 0;
	int unsigned cycles = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned stall_run = 0;

	header_length_trailer_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.byte_role     (byte_role),
		.frame_end     (frame_end),
		.frame_good    (frame_good),
		.frame_too_long(frame_too_long),
		.trigger_number(trigger_number),
		.frame_counter (frame_counter),
		.payload_bytes (payload_bytes),
		.good_frames   (good_frames),
		.limit_reached (limit_reached)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// consumer stall pattern
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 200);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
			default: begin
				if (stall_run != 0) begin
					stall_run--;
					out_stall <= 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_run = $urandom_range(1, 8);
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		endcase
	end

	// outputs are stable between edges; a result seen here is taken at the next edge
	always @(negedge clk) begin
		hltd_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.byte_out = byte_out;
			seen.byte_role = role_t'(byte_role);
			seen.frame_end = frame_end;
			seen.frame_good = frame_good;
			seen.frame_too_long = frame_too_long;
			seen.trigger_number = trigger_number;
			seen.frame_counter = frame_counter;
			seen.payload_bytes = payload_bytes;
			seen.good_frames = good_frames;
			seen.limit_reached = limit_reached;
			sb.check_result(seen);
		end
	end

	task automatic send_byte(input logic [7:0] value);
		bit taken;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_valid && !in_stall;
			@(posedge clk);
		end
		if (sb.predict_byte(value) != ROLE_IGNORED)
			fed_bytes++;
		burst_left--;
	endtask

	task automatic send_noise(input int unsigned count);
		repeat (count) send_byte($urandom_range(0, 255));
	endtask

	task automatic send_frame(input logic [31:0] trig, input logic [31:0] ctr,
			input logic [31:0] count, input int unsigned pay_len,
			input logic [31:0] trailer, input bit with_trailer);
		logic [31:0] hw;
		hw = sb.hdr_word;
		for (int i = 3; i >= 0; i--)
			send_byte(hw[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(trig[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(ctr[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(count[8*i +: 8]);
		send_noise(pay_len);
		if (with_trailer)
			for (int i = 3; i >= 0; i--)
				send_byte(trailer[8*i +: 8]);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [32:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] hw, input logic [30:0] lim,
			input logic [32:0] maxp);
		quiesce();
		write_reg(CFG_HEADER_WORD, {1'b0, hw});
		write_reg(CFG_PACKET_LIMIT, {2'b0, lim});
		write_reg(CFG_MAX_PAYLOAD, maxp);
	endtask

	task automatic random_phase();
		logic [31:0] hw;
		logic [30:0] lim;
		logic [32:0] maxp;
		logic [31:0] count;
		logic [31:0] trailer;
		logic [32:0] doubled;
		int unsigned budget;
		int unsigned kind;
		int plen;
		hw = ($urandom_range(0, 4) == 0) ? HEADER_WORD_RST : 32'($urandom);
		case ($urandom_range(0, 3))
			0:       maxp = MAX_PAYLOAD_RST;
			1:       maxp = $urandom_range(0, 80);
			2:       maxp = 33'h1_FFFF_FFFE;
			default: maxp = '0;
		endcase
		case ($urandom_range(0, 7))
			0:       lim = '0;
			1, 2:    lim = sb.good + 31'($urandom_range(1, 4));
			default: lim = PACKET_LIMIT_RST;
		endcase
		set_config(hw, lim, maxp);
		budget = fed_bytes + $urandom_range(120, 220);
		while (fed_bytes < budget && !sb.limit_hit()) begin
			kind = $urandom_range(0, 9);
			if (kind == 7) begin
				send_noise($urandom_range(1, 12));
			end else begin
				count = $urandom;
				if ({count, 1'b0} <= maxp || $urandom_range(0, 4) != 0)
					count = $urandom_range(0, 24);
				doubled = {count, 1'b0};
				plen = (doubled > maxp) ? 0 : int'(doubled);
				trailer = TRAILER_WORD;
				if ($urandom_range(0, 6) == 0)
					trailer = ($urandom_range(0, 1) == 0) ? 32'($urandom)
						: TRAILER_WORD ^ (32'h1 << $urandom_range(0, 31));
				// short or long payload knocks the frame off its boundary
				if (kind > 7 && plen != 0)
					plen = plen + $urandom_range(0, 6) - 3;
				if (plen < 0)
					plen = 0;
				send_noise($urandom_range(0, 4));
				send_frame($urandom, $urandom, count, plen, trailer, doubled <= maxp);
			end
		end
		if (sb.limit_hit())
			send_noise($urandom_range(3, 8));
	endtask

	initial begin
		int unsigned random_start;
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_HEADER_WORD;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		out_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: overlapping header start, then the basic frame kinds
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'hCC);
		send_frame(32'hFFFF_FFFF, 32'h0, 32'd3, 6, TRAILER_WORD, 1'b1);
		send_frame(32'h0, 32'hFFFF_FFFF, 32'd0, 0, TRAILER_WORD, 1'b1);
		send_frame(32'h1234_5678, 32'hA5A5_A5A5, 32'd1, 2, 32'h9999_9998, 1'b1);
		send_frame(32'h8000_0001, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 0, TRAILER_WORD, 1'b0);
		send_frame(32'h5A5A_5A5A, 32'hC3C3_C3C3, 32'd9991, 0, TRAILER_WORD, 1'b0);

		// length exactly at the maximum, then above it
		set_config(HEADER_WORD_RST, PACKET_LIMIT_RST, 33'd10);
		send_frame($urandom, $urandom, 32'd5, 10, TRAILER_WORD, 1'b1);
		send_frame($urandom, $urandom, 32'd6, 0, TRAILER_WORD, 1'b0);

		// header equal to the trailer: window must restart after frame end
		set_config(32'h9999_9999, PACKET_LIMIT_RST, 33'd0);
		send_frame($urandom, $urandom, 32'd0, 0, TRAILER_WORD, 1'b1);
		send_frame($urandom, $urandom, 32'd0, 0, TRAILER_WORD, 1'b1);
		send_frame($urandom, $urandom, 32'd1, 0, TRAILER_WORD, 1'b0);

		// all-zero header needs four fresh bytes
		set_config(32'h0, PACKET_LIMIT_RST, 33'h1_FFFF_FFFE);
		send_byte(8'h00);
		send_byte(8'h00);
		send_frame($urandom, $urandom, 32'd2, 4, TRAILER_WORD, 1'b1);

		// limit reached, then limit lowered to zero inside a frame
		set_config(32'hFFFF_FFFF, sb.good + 31'd1, MAX_PAYLOAD_RST);
		send_frame($urandom, $urandom, 32'd1, 2, TRAILER_WORD, 1'b1);
		send_noise(3);
		set_config(32'hFFFF_FFFF, PACKET_LIMIT_RST, MAX_PAYLOAD_RST);
		send_frame($urandom, $urandom, 32'd4, 3, TRAILER_WORD, 1'b0);
		set_config(32'hFFFF_FFFF, 31'd0, MAX_PAYLOAD_RST);
		send_noise(5);
		for (int i = 3; i >= 0; i--)
			send_byte(TRAILER_WORD[8*i +: 8]);
		send_noise(4);

		random_start = fed_bytes;
		while (fed_bytes - random_start < RANDOM_BYTES)
			random_phase();

		quiesce();
		repeat (2) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
